[hw/rtl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, opcodes and direction tables of the scent field block.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int OP_W    = 3;
  localparam int CRD_W   = 6;
  localparam int VAL_W   = 32;
  localparam int PT_W    = 16;
  localparam int MV_W    = 2;
  localparam int CFG_W   = 6;
  localparam int FLD_DEP = 4096;
  localparam int WAL_DEP = 1024;
  localparam int RNG_DEP = 256;
  localparam int RNG_W   = VAL_W + 2 * CRD_W;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_WALL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIFF  = 3'd3;
  localparam logic [OP_W-1:0] OP_STEER = 3'd4;

  localparam logic [1:0] REG_AURA = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;

  // Directions E, SE, S, SW, W, NW, N, NE.
  function automatic logic signed [1:0] step_x(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd7: step_x = 2'sd1;
      3'd3, 3'd4, 3'd5: step_x = -2'sd1;
      default:          step_x = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] step_y(input logic [2:0] k);
    case (k)
      3'd1, 3'd2, 3'd3: step_y = 2'sd1;
      3'd5, 3'd6, 3'd7: step_y = -2'sd1;
      default:          step_y = 2'sd0;
    endcase
  endfunction

endpackage

[hw/rtl/sfd_if.sv]
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic                               valid;
  logic                               ready;
  logic [sfd_pkg::OP_W-1:0]           opcode;
  logic [sfd_pkg::CRD_W-1:0]          cell_row;
  logic [sfd_pkg::CRD_W-1:0]          cell_col;
  logic signed [sfd_pkg::VAL_W-1:0]   cell_value;
  logic                               wall_flag;
  logic signed [sfd_pkg::PT_W-1:0]    from_x;
  logic signed [sfd_pkg::PT_W-1:0]    from_y;
  logic signed [sfd_pkg::PT_W-1:0]    to_x;
  logic signed [sfd_pkg::PT_W-1:0]    to_y;

  modport source (output valid, opcode, cell_row, cell_col, cell_value, wall_flag,
                  from_x, from_y, to_x, to_y, input ready);
  modport sink   (input valid, opcode, cell_row, cell_col, cell_value, wall_flag,
                  from_x, from_y, to_x, to_y, output ready);
endinterface

interface sfd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sfd_pkg::VAL_W-1:0]   read_value;
  logic signed [sfd_pkg::MV_W-1:0]    move_x;
  logic signed [sfd_pkg::MV_W-1:0]    move_y;

  modport source (output valid, read_value, move_x, move_y, input ready);
  modport sink   (input valid, read_value, move_x, move_y, output ready);
endinterface

[hw/rtl/sfd_ram.sv]
// ----------------------------------------------------------------------------
// sfd_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/scent_field_diffuse_and_steer_core.sv]
// ----------------------------------------------------------------------------
// scent_field_diffuse_and_steer_core
// Scent field with wall map: cell access, ring diffusion and steering.
// ----------------------------------------------------------------------------
// Commands arrive as beats on in_bus and each produces exactly one result
// beat on out_bus. The cfg port writes aura, map rows and map columns; the
// user must use it only while the block is idle; the block does not enforce it.
// After reset the block clears the scent and wall memories in one pass over
// all 4096 scent addresses; in_bus.ready stays low during that pass.
// Write, wall write and unknown opcodes go from S_EXEC to S_DONE; a read
// adds S_RDGET. A steer makes one scent memory read per direction.
// A diffuse visits each ring cell and, for each zero cell, makes up to eight
// neighbor reads and runs a 35-step serial divider, then writes back each
// stored cell; all of this shares the single scent memory port.
// A finished result waits in an output register; a new command is accepted
// while it waits. If a second result is ready before the first is taken,
// the block holds it until out_bus.ready.
// ----------------------------------------------------------------------------
module scent_field_diffuse_and_steer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  sfd_in_if.sink                    in_bus,
  sfd_out_if.source                 out_bus,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_idx,
  input  logic [sfd_pkg::CFG_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_EXEC, S_RDGET,
    S_DCELL, S_DCHK, S_DNRD, S_DNACC, S_DDIVI, S_DDIV, S_DRWR, S_DWBRD, S_DWBWR,
    S_SMUL, S_SSUM, S_SCHK, S_SCGET, S_SNRD, S_SNCMP, S_SWRD, S_SWCHK, S_DONE
  } state_t;

  state_t state_r;

  logic [4:0]  aura_r;
  logic [5:0]  rows_r, cols_r;
  logic [11:0] clr_r;

  logic [2:0]         op_r;
  logic [5:0]         row_r, col_r;
  logic [31:0]        val_r;
  logic               wflag_r;
  logic signed [15:0] fx_r, fy_r, tx_r, ty_r;

  logic signed [10:0] cy_r, cx_r, cj_r, ci_r;
  logic signed [6:0]  w_r, ro_r, co_r;
  logic [8:0]         cnt_r, wbk_r;
  logic [2:0]         k_r;
  logic signed [34:0] sum_r;
  logic [3:0]         nn_r;
  logic [34:0]        q_r;
  logic [3:0]         rem_r;
  logic [5:0]         dbit_r;
  logic               neg_r;

  logic [32:0]        dxx_r, dyy_r;
  logic [33:0]        d2_r;
  logic signed [31:0] centre_r;
  logic signed [32:0] best_r;
  logic [2:0]         bi_r;

  logic signed [31:0] res_val_r;
  logic signed [1:0]  res_mx_r, res_my_r;
  logic               out_valid_r;
  logic signed [31:0] out_val_r;
  logic signed [1:0]  out_mx_r, out_my_r;

  logic        sc_we, wl_we, wl_wd, wl_rd, rg_we;
  logic [11:0] sc_addr;
  logic [31:0] sc_wd, sc_rd;
  logic [9:0]  wl_addr;
  logic [7:0]  rg_addr;
  logic [sfd_pkg::RNG_W-1:0] rg_wd, rg_rd;

  function automatic logic signed [10:0] trunc256(input logic signed [17:0] x);
    logic signed [17:0] t;
    t = x + (x[17] ? 18'sd255 : 18'sd0);
    return {t[17], t[17:8]};
  endfunction

  logic [4:0]  eff_aura;
  logic [5:0]  radius;
  logic [5:0]  eff_rows, eff_cols;
  logic [10:0] frow_lim, fcol_lim;

  assign eff_aura = (aura_r > 5'd16) ? 5'd16 : aura_r;
  assign radius   = {eff_aura, 1'b0};
  assign eff_rows = (rows_r > 6'd32) ? 6'd32 : rows_r;
  assign eff_cols = (cols_r > 6'd32) ? 6'd32 : cols_r;
  assign frow_lim = {4'd0, eff_rows, 1'b0};
  assign fcol_lim = {4'd0, eff_cols, 1'b0};

  function automatic logic in_fld(input logic signed [10:0] r, input logic signed [10:0] c,
                                  input logic [10:0] rl, input logic [10:0] cl);
    return !r[10] && !c[10] && ($unsigned(r) < rl) && ($unsigned(c) < cl);
  endfunction

  // Diffuse walk coordinates.
  logic signed [10:0] cj, ci, nj, ni;
  logic               c_in, n_in;
  logic signed [6:0]  adv_ro, adv_co;
  logic               adv_last;

  assign cj   = cy_r + 11'(ro_r);
  assign ci   = cx_r + 11'(co_r);
  assign c_in = in_fld(cj, ci, frow_lim, fcol_lim);
  assign nj   = cj_r + 11'(sfd_pkg::step_y(k_r));
  assign ni   = ci_r + 11'(sfd_pkg::step_x(k_r));
  assign n_in = in_fld(nj, ni, frow_lim, fcol_lim);

  always_comb begin
    adv_last = 1'b0;
    adv_ro   = ro_r;
    adv_co   = co_r;
    if (ro_r == -w_r || ro_r == w_r) begin
      if (co_r == w_r) begin
        adv_last = (ro_r == w_r);
        adv_ro   = ro_r + 7'sd1;
        adv_co   = -w_r;
      end else begin
        adv_co = co_r + 7'sd1;
      end
    end else if (co_r == -w_r) begin
      adv_co = w_r;
    end else begin
      adv_ro = ro_r + 7'sd1;
      adv_co = -w_r;
    end
  end

  // Steer coordinates.
  logic signed [16:0] dx, dy;
  logic signed [10:0] scy, scx, sny, snx, swy, swx;
  logic               sc_in, sn_in, sw_in;
  logic signed [1:0]  ksx, ksy, bsx, bsy;
  logic [47:0]        near_p;
  logic [9:0]         am1_sq;
  logic               far, near;
  logic signed [32:0] g_mem;

  assign dx  = 17'(fx_r) - 17'(tx_r);
  assign dy  = 17'(fy_r) - 17'(ty_r);
  assign ksx = sfd_pkg::step_x(k_r);
  assign ksy = sfd_pkg::step_y(k_r);
  assign bsx = sfd_pkg::step_x(bi_r);
  assign bsy = sfd_pkg::step_y(bi_r);
  assign scy = trunc256({fy_r[15], fy_r, 1'b0});
  assign scx = trunc256({fx_r[15], fx_r, 1'b0});
  assign sny = trunc256({fy_r[15], fy_r, 1'b0} + {{7{ksy[1]}}, ksy, 9'd0});
  assign snx = trunc256({fx_r[15], fx_r, 1'b0} + {{7{ksx[1]}}, ksx, 9'd0});
  assign swy = trunc256({{2{fy_r[15]}}, fy_r} + {{8{bsy[1]}}, bsy, 8'd0});
  assign swx = trunc256({{2{fx_r[15]}}, fx_r} + {{8{bsx[1]}}, bsx, 8'd0});
  assign sc_in = in_fld(scy, scx, frow_lim, fcol_lim);
  assign sn_in = in_fld(sny, snx, frow_lim, fcol_lim);
  assign sw_in = in_fld(swy, swx, {5'd0, eff_rows}, {5'd0, eff_cols});
  assign near_p = 48'(d2_r) * 48'd10000;
  assign near   = near_p < 48'd1159266304;
  assign am1_sq = 10'(eff_aura - 5'd1) * 10'(eff_aura - 5'd1);
  assign far    = (eff_aura == 5'd0) || (d2_r > {8'd0, am1_sq, 16'd0});
  assign g_mem  = 33'(signed'(sc_rd)) - 33'(centre_r);

  // Divider step.
  logic [4:0] trial;
  assign trial = {rem_r, q_r[34]};

  logic signed [31:0] mean;
  assign mean = neg_r ? -signed'(q_r[31:0]) : signed'(q_r[31:0]);

  // Memory port control.
  always_comb begin
    sc_we   = 1'b0;
    sc_addr = 12'd0;
    sc_wd   = 32'd0;
    wl_we   = 1'b0;
    wl_addr = 10'd0;
    wl_wd   = 1'b0;
    rg_we   = 1'b0;
    rg_addr = cnt_r[7:0];
    rg_wd   = {mean, cj_r[5:0], ci_r[5:0]};
    case (state_r)
      S_CLR: begin
        sc_we   = 1'b1;
        sc_addr = clr_r;
        wl_we   = 1'b1;
        wl_addr = clr_r[9:0];
      end
      S_EXEC: begin
        sc_addr = {row_r, col_r};
        sc_wd   = val_r;
        sc_we   = (op_r == sfd_pkg::OP_WRITE) &&
                  in_fld(11'(row_r), 11'(col_r), frow_lim, fcol_lim);
        wl_addr = {row_r[4:0], col_r[4:0]};
        wl_wd   = wflag_r;
        wl_we   = (op_r == sfd_pkg::OP_WALL) && (row_r < eff_rows) && (col_r < eff_cols);
      end
      S_DCELL: sc_addr = {cj[5:0], ci[5:0]};
      S_DNRD:  sc_addr = {nj[5:0], ni[5:0]};
      S_DRWR:  rg_we   = 1'b1;
      S_DWBRD: rg_addr = wbk_r[7:0];
      S_DWBWR: begin
        sc_we   = 1'b1;
        sc_addr = rg_rd[11:0];
        sc_wd   = rg_rd[sfd_pkg::RNG_W-1:12];
      end
      S_SCHK:  sc_addr = {scy[5:0], scx[5:0]};
      S_SNRD:  sc_addr = {sny[5:0], snx[5:0]};
      S_SWRD:  wl_addr = {swy[4:0], swx[4:0]};
      default: ;
    endcase
  end

  sfd_ram #(.WIDTH(32), .DEPTH(sfd_pkg::FLD_DEP)) u_scent (
    .clk(clk), .we(sc_we), .addr(sc_addr), .wdata(sc_wd), .rdata(sc_rd));
  sfd_ram #(.WIDTH(1), .DEPTH(sfd_pkg::WAL_DEP)) u_wall (
    .clk(clk), .we(wl_we), .addr(wl_addr), .wdata(wl_wd), .rdata(wl_rd));
  sfd_ram #(.WIDTH(sfd_pkg::RNG_W), .DEPTH(sfd_pkg::RNG_DEP)) u_ring (
    .clk(clk), .we(rg_we), .addr(rg_addr), .wdata(rg_wd), .rdata(rg_rd));

  assign in_bus.ready       = (state_r == S_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_value = out_val_r;
  assign out_bus.move_x     = out_mx_r;
  assign out_bus.move_y     = out_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= 12'd0;
      aura_r      <= 5'd4;
      rows_r      <= 6'd32;
      cols_r      <= 6'd32;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          sfd_pkg::REG_AURA: aura_r <= cfg_wdata[4:0];
          sfd_pkg::REG_ROWS: rows_r <= cfg_wdata;
          sfd_pkg::REG_COLS: cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_bus.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 12'd1;
          if (clr_r == 12'hFFF) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_bus.valid) begin
            op_r      <= in_bus.opcode;
            row_r     <= in_bus.cell_row;
            col_r     <= in_bus.cell_col;
            val_r     <= in_bus.cell_value;
            wflag_r   <= in_bus.wall_flag;
            fx_r      <= in_bus.from_x;
            fy_r      <= in_bus.from_y;
            tx_r      <= in_bus.to_x;
            ty_r      <= in_bus.to_y;
            res_val_r <= 32'sd0;
            res_mx_r  <= 2'sd0;
            res_my_r  <= 2'sd0;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          cy_r  <= scy;
          cx_r  <= scx;
          w_r   <= 7'sd1;
          ro_r  <= -7'sd1;
          co_r  <= -7'sd1;
          cnt_r <= 9'd0;
          case (op_r)
            sfd_pkg::OP_READ:  state_r <= S_RDGET;
            sfd_pkg::OP_DIFF:  state_r <= (radius == 6'd0) ? S_DONE : S_DCELL;
            sfd_pkg::OP_STEER: state_r <= S_SMUL;
            default:           state_r <= S_DONE;
          endcase
        end
        S_RDGET: begin
          if (in_fld(11'(row_r), 11'(col_r), frow_lim, fcol_lim)) begin
            res_val_r <= sc_rd;
          end
          state_r <= S_DONE;
        end
        S_DCELL: begin
          cj_r <= cj;
          ci_r <= ci;
          if (c_in) begin
            state_r <= S_DCHK;
          end else begin
            ro_r    <= adv_ro;
            co_r    <= adv_co;
            wbk_r   <= 9'd0;
            state_r <= adv_last ? S_DWBRD : S_DCELL;
          end
        end
        S_DCHK: begin
          k_r   <= 3'd0;
          sum_r <= 35'sd0;
          nn_r  <= 4'd0;
          if (sc_rd == 32'd0) begin
            state_r <= S_DNRD;
          end else begin
            ro_r    <= adv_ro;
            co_r    <= adv_co;
            wbk_r   <= 9'd0;
            state_r <= adv_last ? S_DWBRD : S_DCELL;
          end
        end
        S_DNRD: begin
          if (n_in) begin
            state_r <= S_DNACC;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= (k_r == 3'd7) ? S_DDIVI : S_DNRD;
          end
        end
        S_DNACC: begin
          sum_r   <= sum_r + 35'(signed'(sc_rd));
          nn_r    <= nn_r + 4'd1;
          k_r     <= k_r + 3'd1;
          state_r <= (k_r == 3'd7) ? S_DDIVI : S_DNRD;
        end
        S_DDIVI: begin
          neg_r   <= sum_r[34];
          q_r     <= (nn_r == 4'd0) ? 35'd0 : (sum_r[34] ? 35'(-sum_r) : 35'(sum_r));
          rem_r   <= 4'd0;
          dbit_r  <= 6'd0;
          state_r <= (nn_r == 4'd0) ? S_DRWR : S_DDIV;
        end
        S_DDIV: begin
          if (trial >= {1'b0, nn_r}) begin
            rem_r <= 4'(trial - {1'b0, nn_r});
            q_r   <= {q_r[33:0], 1'b1};
          end else begin
            rem_r <= trial[3:0];
            q_r   <= {q_r[33:0], 1'b0};
          end
          dbit_r <= dbit_r + 6'd1;
          if (dbit_r == 6'd34) begin
            state_r <= S_DRWR;
          end
        end
        S_DRWR: begin
          cnt_r   <= cnt_r + 9'd1;
          ro_r    <= adv_ro;
          co_r    <= adv_co;
          wbk_r   <= 9'd0;
          state_r <= adv_last ? S_DWBRD : S_DCELL;
        end
        S_DWBRD: begin
          if (cnt_r == 9'd0 || wbk_r == cnt_r) begin
            w_r     <= w_r + 7'sd1;
            ro_r    <= -(w_r + 7'sd1);
            co_r    <= -(w_r + 7'sd1);
            cnt_r   <= 9'd0;
            state_r <= (w_r == 7'(radius)) ? S_DONE : S_DCELL;
          end else begin
            state_r <= S_DWBWR;
          end
        end
        S_DWBWR: begin
          wbk_r   <= wbk_r + 9'd1;
          state_r <= S_DWBRD;
        end
        S_SMUL: begin
          dxx_r   <= 33'(dx * dx);
          dyy_r   <= 33'(dy * dy);
          state_r <= S_SSUM;
        end
        S_SSUM: begin
          d2_r    <= 34'(dxx_r) + 34'(dyy_r);
          state_r <= S_SCHK;
        end
        S_SCHK: begin
          k_r      <= 3'd0;
          centre_r <= 32'sd0;
          if (near || far) begin
            state_r <= S_DONE;
          end else begin
            state_r <= sc_in ? S_SCGET : S_SNRD;
          end
        end
        S_SCGET: begin
          centre_r <= sc_rd;
          state_r  <= S_SNRD;
        end
        S_SNRD: begin
          if (sn_in) begin
            state_r <= S_SNCMP;
          end else begin
            if (k_r == 3'd0 || best_r < 33'sd0) begin
              best_r <= 33'sd0;
              bi_r   <= k_r;
            end
            k_r     <= k_r + 3'd1;
            state_r <= (k_r == 3'd7) ? S_SWRD : S_SNRD;
          end
        end
        S_SNCMP: begin
          if (k_r == 3'd0 || g_mem > best_r) begin
            best_r <= g_mem;
            bi_r   <= k_r;
          end
          k_r     <= k_r + 3'd1;
          state_r <= (k_r == 3'd7) ? S_SWRD : S_SNRD;
        end
        S_SWRD: begin
          state_r <= sw_in ? S_SWCHK : S_DONE;
        end
        S_SWCHK: begin
          if (!wl_rd) begin
            res_mx_r <= bsx;
            res_my_r <= bsy;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_mx_r    <= res_mx_r;
            out_my_r    <= res_my_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
